FILE: rtl/lcsd_pkg.sv
// shared codes and controller/datapath interface types for the lcs line diff unit
package lcsd_pkg;

  localparam int KIND_W = 3;
  localparam int IDX_W  = 6;
  localparam int OP_W   = 2;
  localparam int SYM_IN_W = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_OLD    = 2'd0;
  localparam logic [OP_W-1:0] OP_NEW    = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN    = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] K_EQ    = 3'd0;
  localparam logic [KIND_W-1:0] K_ADD   = 3'd1;
  localparam logic [KIND_W-1:0] K_DEL   = 3'd2;
  localparam logic [KIND_W-1:0] K_EMPTY = 3'd3;
  localparam logic [KIND_W-1:0] K_LONG  = 3'd4;

  // script entry kinds, two bits
  localparam logic [1:0] SK_EQ  = 2'd0;
  localparam logic [1:0] SK_ADD = 2'd1;
  localparam logic [1:0] SK_DEL = 2'd2;

  localparam logic [IDX_W-1:0] IDX_NONE = 6'h3f;

  typedef struct packed {
    logic load;
    logic fill_init;
    logic fill_rd;
    logic fill_wr;
    logic bt_init;
    logic bt_rd;
    logic bt_step;
    logic out_rd;
    logic spec_long;
    logic spec_empty;
    logic clear;
  } lcsd_cmd_t;

  typedef struct packed {
    logic ovf;
    logic old_zero;
    logic new_zero;
    logic fill_done;
    logic bt_done;
    logic last;
  } lcsd_stat_t;

endpackage

FILE: rtl/lcs_line_diff_edit_script_unit.sv
// top level of the lcs line diff edit script unit
//
// Input channel (in_valid/in_ready): each word carries an operation and a
// line token. Operation 0 appends the token to the old sequence, 1 to the
// new sequence, 2 runs the diff; code 3 is taken and ignored. Appends are
// accepted back to back.
// A run spends a check state, then fills the score table cell by cell, each
// cell a read on the two-port score memory, then a compute/write step;
// then a setup step and a backtrack, each step a read and then a step
// state, closed by a final check; fill and setup are skipped when one
// sequence is empty. The edit script is then delivered in forward order,
// each result word a script buffer read, then present. in_ready is low from
// the run word until the word with out_last has been taken.
// Output channel (out_valid/out_ready): kind, old/new line index (-1 when
// none) and last. A stalled receiver just holds the current word; nothing
// is lost. After an overflowed load a single too-long word is given, after
// two empty sequences a single empty word. A run clears both sequences.
// Reset (rst_n low, synchronous) empties both sequences and the overflow
// flag and returns to waiting for input words.
module lcs_line_diff_edit_script_unit
  import lcsd_pkg::*;
#(
  parameter int MAX_LINES    = 32,
  parameter int SYMBOL_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [SYM_IN_W-1:0]     in_symbol,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [KIND_W-1:0]       out_kind,
  output logic signed [IDX_W-1:0] out_old_index,
  output logic signed [IDX_W-1:0] out_new_index,
  output logic                    out_last
);

  lcsd_cmd_t  cmd;
  lcsd_stat_t stat;

  // sequencer
  lcsd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // storage and arithmetic
  lcsd_dp #(
    .MAX_LINES    (MAX_LINES),
    .SYMBOL_WIDTH (SYMBOL_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_operation  (in_operation),
    .in_symbol     (in_symbol),
    .out_kind      (out_kind),
    .out_old_index (out_old_index),
    .out_new_index (out_new_index),
    .out_last      (out_last)
  );

endmodule

FILE: rtl/lcsd_ctrl.sv
// controller state machine sequencing load, table fill, backtrack and output
module lcsd_ctrl
  import lcsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [OP_W-1:0] in_operation,
  output logic       out_valid,
  input  logic       out_ready,
  input  lcsd_stat_t stat,
  output lcsd_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;
  localparam logic [3:0] S_F_RD   = 4'd2;
  localparam logic [3:0] S_F_WR   = 4'd3;
  localparam logic [3:0] S_B_INIT = 4'd4;
  localparam logic [3:0] S_B_RD   = 4'd5;
  localparam logic [3:0] S_B_STEP = 4'd6;
  localparam logic [3:0] S_O_RD   = 4'd7;
  localparam logic [3:0] S_O_VAL  = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_O_VAL);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_operation == OP_RUN) state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        priority if (stat.ovf) begin
          cmd.spec_long = 1'b1;
          state_nxt = S_O_VAL;
        end else if (stat.old_zero && stat.new_zero) begin
          cmd.spec_empty = 1'b1;
          state_nxt = S_O_VAL;
        end else if (stat.old_zero || stat.new_zero) begin
          cmd.bt_init = 1'b1;
          state_nxt = S_B_RD;
        end else begin
          cmd.fill_init = 1'b1;
          state_nxt = S_F_RD;
        end
      end
      S_F_RD: begin
        cmd.fill_rd = 1'b1;
        state_nxt = S_F_WR;
      end
      S_F_WR: begin
        cmd.fill_wr = 1'b1;
        state_nxt = stat.fill_done ? S_B_INIT : S_F_RD;
      end
      S_B_INIT: begin
        cmd.bt_init = 1'b1;
        state_nxt = S_B_RD;
      end
      S_B_RD: begin
        if (stat.bt_done) begin
          state_nxt = S_O_RD;
        end else begin
          cmd.bt_rd = 1'b1;
          state_nxt = S_B_STEP;
        end
      end
      S_B_STEP: begin
        cmd.bt_step = 1'b1;
        state_nxt = S_B_RD;
      end
      S_O_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt = S_O_VAL;
      end
      S_O_VAL: begin
        if (out_ready) begin
          if (stat.last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_O_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: rtl/lcsd_dp.sv
// datapath: line stores, score table, script buffer, counters and output word
module lcsd_dp
  import lcsd_pkg::*;
#(
  parameter int MAX_LINES    = 32,
  parameter int SYMBOL_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcsd_cmd_t            cmd,
  output lcsd_stat_t           stat,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [SYM_IN_W-1:0]  in_symbol,
  output logic [KIND_W-1:0]    out_kind,
  output logic signed [IDX_W-1:0] out_old_index,
  output logic signed [IDX_W-1:0] out_new_index,
  output logic                 out_last
);

  localparam int SW     = (SYMBOL_WIDTH > SYM_IN_W) ? SYM_IN_W : SYMBOL_WIDTH;
  localparam int AW     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int LW     = $clog2(MAX_LINES + 1);
  localparam int STRIDE = MAX_LINES + 1;
  localparam int TDEPTH = STRIDE * STRIDE;
  localparam int TW     = $clog2(TDEPTH);
  localparam int SDEPTH = 2 * MAX_LINES;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int CW     = $clog2(SDEPTH + 1);
  localparam int EW     = 2 + 2 * AW;

  // memories
  logic [SW-1:0] old_mem [MAX_LINES];
  logic [SW-1:0] new_mem [MAX_LINES];
  logic [LW-1:0] sc_mem  [TDEPTH];
  logic [EW-1:0] sb_mem  [SDEPTH];

  logic [LW-1:0] old_len_r, new_len_r;
  logic          ovf_r;
  logic [LW-1:0] i_r, j_r, left_r;
  logic [CW-1:0] cnt_r;
  logic [SW-1:0] old_q_r, new_q_r;
  logic [LW-1:0] sa_q_r, sb_q_r;
  logic          iz_r, jz_r, ib_r, jb_r;
  logic [EW-1:0] ent_q_r;
  logic          special_r, last_r;
  logic [KIND_W-1:0] spec_kind_r;

  logic [LW-1:0] im1, jm1;
  logic [TW-1:0] addr_a, addr_b, addr_w;
  logic          match;
  logic [LW-1:0] up_v, left_v, diag_v, cell_v;
  logic [1:0]    step_kind;
  logic [EW-1:0] step_ent;
  logic [SAW-1:0] rd_sb;
  logic [1:0]    ent_kind;
  logic [AW-1:0] ent_oi, ent_ni;

  assign im1 = i_r - LW'(1);
  assign jm1 = j_r - LW'(1);

  // score table addresses: fill reads up/diag, backtrack reads left/up
  always_comb begin
    if (cmd.fill_rd) begin
      addr_a = TW'(im1) * TW'(STRIDE) + TW'(j_r);
      addr_b = TW'(im1) * TW'(STRIDE) + TW'(jm1);
    end else begin
      addr_a = TW'(i_r) * TW'(STRIDE) + TW'(jm1);
      addr_b = TW'(im1) * TW'(STRIDE) + TW'(j_r);
    end
    addr_w = TW'(i_r) * TW'(STRIDE) + TW'(j_r);
  end

  // fill cell value, borders read as zero
  always_comb begin
    match  = (old_q_r == new_q_r);
    up_v   = ib_r ? '0 : sa_q_r;
    diag_v = (ib_r || jb_r) ? '0 : sb_q_r;
    left_v = jb_r ? '0 : left_r;
    if (match)              cell_v = diag_v + LW'(1);
    else if (up_v >= left_v) cell_v = up_v;
    else                    cell_v = left_v;
  end

  // backtrack decision: match, then add, then delete
  logic [LW-1:0] bt_left, bt_up;
  always_comb begin
    bt_left = jb_r ? '0 : sa_q_r;
    bt_up   = ib_r ? '0 : sb_q_r;
    if (!iz_r && !jz_r && match)               step_kind = SK_EQ;
    else if (!jz_r && (iz_r || bt_left >= bt_up)) step_kind = SK_ADD;
    else                                       step_kind = SK_DEL;
    step_ent = {step_kind, AW'(im1), AW'(jm1)};
  end

  assign rd_sb = SAW'(cnt_r - CW'(1));

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.load && in_operation == OP_OLD && old_len_r < LW'(MAX_LINES))
      old_mem[AW'(old_len_r)] <= in_symbol[SW-1:0];
    if (cmd.load && in_operation == OP_NEW && new_len_r < LW'(MAX_LINES))
      new_mem[AW'(new_len_r)] <= in_symbol[SW-1:0];
    if (cmd.fill_rd || cmd.bt_rd) begin
      old_q_r <= old_mem[AW'(im1)];
      new_q_r <= new_mem[AW'(jm1)];
      sa_q_r  <= sc_mem[addr_a];
      sb_q_r  <= sc_mem[addr_b];
    end
    if (cmd.fill_wr) sc_mem[addr_w] <= cell_v;
    if (cmd.bt_step) sb_mem[SAW'(cnt_r)] <= step_ent;
    if (cmd.out_rd)  ent_q_r <= sb_mem[rd_sb];
  end

  // border and end flags captured with the reads
  always_ff @(posedge clk) begin
    if (cmd.fill_rd || cmd.bt_rd) begin
      iz_r <= (i_r == '0);
      jz_r <= (j_r == '0);
      ib_r <= (i_r == LW'(1));
      jb_r <= (j_r == LW'(1));
    end
  end

  // lengths, overflow, walk counters and output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_len_r <= '0;
      new_len_r <= '0;
      ovf_r     <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      cnt_r     <= '0;
      left_r    <= '0;
      special_r <= 1'b0;
      last_r    <= 1'b0;
      spec_kind_r <= K_EMPTY;
    end else begin
      if (cmd.load) begin
        if (in_operation == OP_OLD) begin
          if (old_len_r < LW'(MAX_LINES)) old_len_r <= old_len_r + LW'(1);
          else                            ovf_r <= 1'b1;
        end else if (in_operation == OP_NEW) begin
          if (new_len_r < LW'(MAX_LINES)) new_len_r <= new_len_r + LW'(1);
          else                            ovf_r <= 1'b1;
        end
      end
      if (cmd.fill_init) begin
        i_r <= LW'(1);
        j_r <= LW'(1);
      end
      if (cmd.fill_wr) begin
        left_r <= cell_v;
        if (j_r == new_len_r) begin
          j_r <= LW'(1);
          i_r <= i_r + LW'(1);
        end else begin
          j_r <= j_r + LW'(1);
        end
      end
      if (cmd.bt_init) begin
        i_r   <= old_len_r;
        j_r   <= new_len_r;
        cnt_r <= '0;
      end
      if (cmd.bt_step) begin
        cnt_r <= cnt_r + CW'(1);
        if (step_kind != SK_DEL) j_r <= jm1;
        if (step_kind != SK_ADD) i_r <= im1;
      end
      if (cmd.out_rd) begin
        special_r <= 1'b0;
        last_r    <= (cnt_r == CW'(1));
        cnt_r     <= cnt_r - CW'(1);
      end
      if (cmd.spec_long || cmd.spec_empty) begin
        special_r   <= 1'b1;
        last_r      <= 1'b1;
        spec_kind_r <= cmd.spec_long ? K_LONG : K_EMPTY;
      end
      if (cmd.clear) begin
        old_len_r <= '0;
        new_len_r <= '0;
        ovf_r     <= 1'b0;
      end
    end
  end

  // status to controller
  assign stat.ovf       = ovf_r;
  assign stat.old_zero  = (old_len_r == '0);
  assign stat.new_zero  = (new_len_r == '0);
  assign stat.fill_done = (i_r == old_len_r) && (j_r == new_len_r);
  assign stat.bt_done   = (i_r == '0) && (j_r == '0);
  assign stat.last      = last_r;

  // output word
  assign ent_kind = ent_q_r[EW-1 -: 2];
  assign ent_oi   = ent_q_r[2*AW-1 -: AW];
  assign ent_ni   = ent_q_r[AW-1:0];

  always_comb begin
    if (special_r) begin
      out_kind      = spec_kind_r;
      out_old_index = IDX_NONE;
      out_new_index = IDX_NONE;
    end else begin
      out_kind      = {1'b0, ent_kind};
      out_old_index = (ent_kind == SK_ADD) ? IDX_NONE : IDX_W'(ent_oi);
      out_new_index = (ent_kind == SK_DEL) ? IDX_NONE : IDX_W'(ent_ni);
    end
  end
  assign out_last = last_r;

endmodule
